FILE: design/assert_macros.svh
// assertion macros for the allocator
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold every cycle outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/ffba_pkg.sv
// types and constants shared by the allocator modules
// no dependencies
`default_nettype none
package ffba_pkg;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_STATS = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_BADPTR  = 2'd3;

  localparam logic [1:0] BLK_FREE  = 2'd0;
  localparam logic [1:0] BLK_ALLOC = 2'd1;
  localparam logic [1:0] BLK_SYS   = 2'd2;

  localparam logic [0:0] CFG_HEAP_FIRST = 1'b0;
  localparam logic [0:0] CFG_HEAP_LAST  = 1'b1;

  localparam logic [19:0] HEAP_FIRST_RESET = 20'd131072;
  localparam logic [19:0] HEAP_LAST_RESET  = 20'd655359;
  localparam int unsigned PCT_SCALE = 100;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [20:0] size_bytes;
    logic [19:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] result_address;
    logic [7:0]  first_block;
    logic [8:0]  block_count;
    logic [8:0]  free_block_total;
    logic [8:0]  allocated_block_total;
    logic [6:0]  fragmentation_pct;
    logic [20:0] heap_used_bytes;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;   // reset sweep write
    logic load;         // capture request
    logic scan_step;    // one table entry for alloc or stats
    logic mark_step;    // write one block of alloc
    logic fchk_step;    // read header block of free
    logic free_step;    // free one block
    logic div_start;
    logic div_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic zero_size;
    logic ptr_bad;
    logic found;
    logic scan_last;
    logic mark_last;
    logic hdr_ok;
    logic free_last;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/ffba_ctrl.sv
// controller state machine of the allocator
// depends on ffba_pkg
`default_nettype none
module ffba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    req_type,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ffba_pkg::cmd_t     cmd,
  input  wire ffba_pkg::sts_t sts,
  output logic               rsp_load,
  output logic [1:0]         rsp_kind
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_DECODE = 10'b0000000100,
    S_SCAN   = 10'b0000001000,
    S_MARK   = 10'b0000010000,
    S_FCHK   = 10'b0000100000,
    S_FCHK2  = 10'b0001000000,
    S_FREE   = 10'b0010000000,
    S_DIV    = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] kind, kind_next;
  logic       pend, pend_next;

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign out_valid = pend;

  always_comb begin
    state_next = state;
    kind_next  = kind;
    pend_next  = pend;
    cmd        = '0;
    rsp_load   = 1'b0;
    rsp_kind   = kind;
    if (out_valid && out_ready) begin
      pend_next = 1'b0;
    end
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          kind_next  = req_type;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (kind)
          ffba_pkg::REQ_ALLOC: state_next = sts.zero_size ? S_DONE : S_SCAN;
          ffba_pkg::REQ_FREE:  state_next = sts.ptr_bad ? S_DONE : S_FCHK;
          ffba_pkg::REQ_STATS: state_next = S_SCAN;
          default:             state_next = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (kind == ffba_pkg::REQ_ALLOC && sts.found) begin
          state_next = S_MARK;
        end else if (sts.scan_last) begin
          if (kind == ffba_pkg::REQ_STATS) begin
            state_next = S_DIV;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_last) begin
          state_next = S_DONE;
        end
      end
      S_FCHK: begin
        cmd.fchk_step = 1'b1;
        state_next    = S_FCHK2;
      end
      S_FCHK2: begin
        state_next = sts.hdr_ok ? S_FREE : S_DONE;
      end
      S_FREE: begin
        cmd.free_step = 1'b1;
        if (sts.free_last) begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!pend || out_ready) begin
          rsp_load   = 1'b1;
          pend_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_SCAN && state_next == S_DIV) begin
      cmd.div_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pend  <= 1'b0;
      kind  <= ffba_pkg::REQ_ALLOC;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      kind  <= kind_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/ffba_datapath.sv
// block table, scan counters, divider and result register
// depends on ffba_pkg
`default_nettype none
module ffba_datapath #(
  parameter int NUM_BLOCKS      = 256,
  parameter int BLOCK_BYTES     = 4096,
  parameter int HEADER_BYTES    = 8,
  parameter int RESERVED_BLOCKS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ffba_pkg::req_t    req,
  input  wire ffba_pkg::cmd_t    cmd,
  output ffba_pkg::sts_t         sts,
  input  wire logic              rsp_load,
  input  wire logic [1:0]        rsp_kind,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_idx,
  input  wire logic [19:0]       cfg_data,
  output ffba_pkg::rsp_t         rsp
);

  localparam int IW  = $clog2(NUM_BLOCKS);
  localparam int CW  = IW + 1;
  localparam int BSH = $clog2(BLOCK_BYTES);
  localparam logic [CW-1:0] NB = CW'(NUM_BLOCKS);
  localparam logic [CW-1:0] RB = CW'(RESERVED_BLOCKS);

  // one memory holds status and request size per block
  logic [22:0] mem [NUM_BLOCKS];
  logic [22:0] rd;
  logic [IW-1:0] waddr, raddr;
  logic          we;
  logic [22:0]   wdata;

  logic [19:0] heap_first, heap_last;
  ffba_pkg::req_t r;
  logic [20:0] used;
  logic [CW-1:0] idx;        // sweep or scan position
  logic [CW-1:0] need;
  logic          need_big;
  logic [CW-1:0] run, start;
  logic          found;
  logic          in_run;
  logic [CW-1:0] nfree, nalloc, nruns;
  logic [CW-1:0] mcnt;       // blocks written so far
  logic [CW-1:0] fidx, fcnt, fn;
  logic [1:0]    vstat;      // status of entry just read
  logic          rd_valid;
  logic          hdr_rd;     // rd holds the header block of a free

  // divider
  logic [15:0] quot;
  logic [CW+7:0] rem;
  logic [CW+7:0] dvd;
  logic [4:0]    dstep;

  function automatic logic [CW:0] blocks_for(input logic [20:0] sz);
    logic [BSH+21:0] t;
    t = (BSH+22)'(sz) + (BSH+22)'(HEADER_BYTES) + (BSH+22)'(BLOCK_BYTES - 1);
    return (CW+1)'(t >> BSH);
  endfunction

  logic [CW:0]  need_w;
  logic [CW:0]  fneed_w;
  logic [20:0]  addr_off;
  logic [20:0]  hdr_blk;
  assign need_w   = blocks_for(r.size_bytes);
  assign addr_off = 21'(r.address) - 21'(HEADER_BYTES);
  assign hdr_blk  = addr_off >> BSH;
  assign fneed_w  = blocks_for(rd[20:0]);

  // memory read address
  always_comb begin
    raddr = idx[IW-1:0];
    if (cmd.fchk_step) raddr = hdr_blk[IW-1:0];
    if (cmd.free_step) raddr = fidx[IW-1:0] + IW'(fcnt);
  end

  always_ff @(posedge clk) begin
    rd <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  // writes
  always_comb begin
    we = 1'b0;
    waddr = idx[IW-1:0];
    wdata = '0;
    if (cmd.clear_step) begin
      we = 1'b1;
      wdata = {(idx < RB) ? ffba_pkg::BLK_SYS : ffba_pkg::BLK_FREE, 21'd0};
    end else if (cmd.mark_step) begin
      we = 1'b1;
      waddr = start[IW-1:0] + IW'(mcnt);
      wdata = {ffba_pkg::BLK_ALLOC, r.size_bytes};
    end else if (rd_valid && rd[22:21] == ffba_pkg::BLK_ALLOC && fcnt != 0
                 && cmd.free_step) begin
      we = 1'b1;
      waddr = fidx[IW-1:0] + IW'(fcnt - 1'b1);
      wdata = {ffba_pkg::BLK_FREE, 21'd0};
    end
  end

  assign vstat = rd[22:21];

  always_comb begin
    sts = '0;
    sts.clear_done = (idx == NB - 1'b1);
    sts.zero_size  = (r.size_bytes == 21'd0);
    sts.ptr_bad    = (r.address < 20'(HEADER_BYTES)) || (r.address == 20'd0)
                   || (r.address < heap_first) || (r.address > heap_last)
                   || (hdr_blk >= 21'(NUM_BLOCKS));
    sts.found      = found;
    sts.scan_last  = (idx == NB) && !rd_valid;
    sts.mark_last  = (mcnt == need - 1'b1);
    sts.hdr_ok     = (vstat == ffba_pkg::BLK_ALLOC);
    sts.free_last  = (fcnt == fn);
    sts.div_done   = (dstep == 5'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_first <= ffba_pkg::HEAP_FIRST_RESET;
      heap_last  <= ffba_pkg::HEAP_LAST_RESET;
      used       <= '0;
      idx        <= '0;
      rd_valid   <= 1'b0;
      hdr_rd     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          ffba_pkg::CFG_HEAP_FIRST: heap_first <= cfg_data;
          ffba_pkg::CFG_HEAP_LAST:  heap_last  <= cfg_data;
          default: ;
        endcase
      end
      rd_valid <= cmd.scan_step && idx != NB;
      hdr_rd   <= cmd.fchk_step;
      if (cmd.clear_step) begin
        idx <= idx + 1'b1;
      end
      if (cmd.load) begin
        r      <= req;
        idx    <= '0;
        run    <= '0;
        found  <= 1'b0;
        in_run <= 1'b0;
        nfree  <= '0;
        nalloc <= '0;
        nruns  <= '0;
        mcnt   <= '0;
        fcnt   <= '0;
      end
      if (cmd.scan_step) begin
        // read data belongs to the entry before idx
        if (idx != NB) idx <= idx + 1'b1;
        need     <= need_w[CW] ? '1 : need_w[CW-1:0];
        need_big <= need_w > (CW+1)'(NUM_BLOCKS);
        if (rd_valid) begin
          if (vstat == ffba_pkg::BLK_FREE) begin
            nfree <= nfree + 1'b1;
            if (!in_run) nruns <= nruns + 1'b1;
            in_run <= 1'b1;
            if (run == 0) start <= idx - 1'b1;
            run <= run + 1'b1;
            if (!need_big && run + 1'b1 >= need && need != 0) found <= 1'b1;
          end else begin
            if (vstat == ffba_pkg::BLK_ALLOC) nalloc <= nalloc + 1'b1;
            in_run <= 1'b0;
            run    <= '0;
          end
        end
      end
      if (cmd.mark_step) begin
        mcnt <= mcnt + 1'b1;
      end
      if (rsp_load && rsp_kind == ffba_pkg::REQ_ALLOC && found) begin
        used <= (22'(used) + (22'(need) << BSH) > 22'h1FFFFF) ? 21'h1FFFFF
              : used + (21'(need) << BSH);
      end
      if (cmd.fchk_step) begin
        fidx <= CW'(hdr_blk);
        fcnt <= '0;
      end
      if (hdr_rd) begin
        fn <= (fneed_w > (CW+1)'(NB - fidx)) ? NB - fidx : fneed_w[CW-1:0];
        if (fneed_w == 0) fn <= '0;
      end
      if (cmd.free_step) begin
        fcnt <= fcnt + 1'b1;
        rd_valid <= 1'b1;
      end
      if (rsp_load && rsp_kind == ffba_pkg::REQ_FREE && fcnt != 0) begin
        used <= ((22'(fn) << BSH) >= 22'(used)) ? '0 : used - (21'(fn) << BSH);
      end
      if (cmd.div_start) begin
        dvd   <= (CW+8)'(nruns) * (CW+8)'(ffba_pkg::PCT_SCALE);
        rem   <= '0;
        quot  <= '0;
        dstep <= 5'(CW + 7);
      end else if (cmd.div_step) begin
        if ({rem[CW+6:0], dvd[CW+7]} >= (CW+8)'(nfree)) begin
          rem  <= {rem[CW+6:0], dvd[CW+7]} - (CW+8)'(nfree);
          quot <= {quot[14:0], 1'b1};
        end else begin
          rem  <= {rem[CW+6:0], dvd[CW+7]};
          quot <= {quot[14:0], 1'b0};
        end
        dvd   <= dvd << 1;
        dstep <= dstep - 1'b1;
      end
    end
  end

  logic [20:0] used_after;
  always_comb begin
    used_after = used;
    if (rsp_kind == ffba_pkg::REQ_ALLOC && found) begin
      used_after = (22'(used) + (22'(need) << BSH) > 22'h1FFFFF) ? 21'h1FFFFF
                 : used + (21'(need) << BSH);
    end else if (rsp_kind == ffba_pkg::REQ_FREE && fcnt != 0) begin
      used_after = ((22'(fn) << BSH) >= 22'(used)) ? '0 : used - (21'(fn) << BSH);
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= '0;
      rsp.heap_used_bytes <= used_after;
      case (rsp_kind)
        ffba_pkg::REQ_ALLOC: begin
          if (r.size_bytes == 0) begin
            rsp.status <= ffba_pkg::ST_ZERO;
          end else if (!found) begin
            rsp.status <= ffba_pkg::ST_NOSPACE;
          end else begin
            rsp.result_address <= 20'((32'(start) << BSH) + 32'(HEADER_BYTES));
            rsp.first_block    <= 8'(start);
            rsp.block_count    <= 9'(need);
          end
        end
        ffba_pkg::REQ_FREE: begin
          if (fcnt == 0) begin
            rsp.status <= ffba_pkg::ST_BADPTR;
          end else begin
            rsp.first_block <= 8'(fidx);
            rsp.block_count <= 9'(fn);
          end
        end
        ffba_pkg::REQ_STATS: begin
          rsp.free_block_total      <= 9'(nfree);
          rsp.allocated_block_total <= 9'(nalloc);
          rsp.fragmentation_pct     <= (nfree == 0) ? 7'd0 : 7'(quot);
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/first_fit_block_allocator.sv
// top level of the first-fit block allocator
// depends on ffba_pkg, ffba_ctrl, ffba_datapath, assert_macros.svh
// After reset a clearing pass initializes the block table; no request is
// taken until it ends. One request is handled at a time. Allocate and
// statistics scan the table one entry per cycle from a single memory port,
// then allocate writes the needed blocks one per cycle and statistics runs
// a bit-serial divide. Free reads and checks the header block, then frees
// the blocks that it covers.
`default_nettype none
`include "assert_macros.svh"
module first_fit_block_allocator #(
  parameter int NUM_BLOCKS      = 256,
  parameter int BLOCK_BYTES     = 4096,
  parameter int HEADER_BYTES    = 8,
  parameter int RESERVED_BLOCKS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ffba_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ffba_pkg::rsp_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic [0:0]     cfg_index,
  input  wire logic [19:0]    cfg_data
);

  ffba_pkg::cmd_t cmd;
  ffba_pkg::sts_t sts;
  logic       rsp_load;
  logic [1:0] rsp_kind;
  logic [3:0] step_cmds;

  assign step_cmds = {cmd.clear_step, cmd.scan_step, cmd.mark_step, cmd.free_step};

  ffba_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .req_type(in_data.req_type),
    .out_valid, .out_ready, .cmd, .sts, .rsp_load, .rsp_kind
  );

  ffba_datapath #(
    .NUM_BLOCKS(NUM_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES),
    .HEADER_BYTES(HEADER_BYTES), .RESERVED_BLOCKS(RESERVED_BLOCKS)
  ) u_dp (
    .clk, .rst, .req(in_data), .cmd, .sts, .rsp_load, .rsp_kind,
    .cfg_we, .cfg_idx(cfg_index), .cfg_data, .rsp(out_data)
  );

  `ASSERT_ALWAYS(a_one_cmd, clk, rst, $onehot0(step_cmds))
  `ASSERT_NEXT(a_load_sets_valid, clk, rst, rsp_load, out_valid)
  `ASSERT_ALWAYS(a_no_load_when_busy, clk, rst, !(cmd.load && (cmd.scan_step || cmd.mark_step)))

endmodule
`default_nettype wire

FILE: verif/ffba_checker.sv
// checker for the first-fit block allocator: models the block table,
// predicts each response and compares it with what the dut returns
// depends on ffba_pkg
module ffba_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  ffba_pkg::req_t  in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  ffba_pkg::rsp_t  out_data,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [19:0]     cfg_data,
  output int              fail_count,
  output int              pending,
  output int              resp_seen,
  output int              alloc_ok_seen,
  output int              free_ok_seen
);
  import ffba_pkg::*;

  localparam int NBLK = 256;
  localparam int BBYTES = 4096;
  localparam int HDR = 8;
  localparam int RSV = 32;
  localparam longint USED_MAX = 64'h1FFFFF;

  logic [1:0]  blk_state [NBLK];
  logic [20:0] blk_owner_size [NBLK];
  logic [20:0] used_total;
  logic [19:0] win_lo, win_hi;
  rsp_t        expected_rsp [$];

  function automatic longint blocks_for(longint sz);
    return (sz + HDR + BBYTES - 1) / BBYTES;
  endfunction

  task automatic predict(input req_t rq, output rsp_t r);
    longint need, run, start, idx, n, nfree, nalloc, runs, t;
    bit found, in_run;
    r = '0;
    if (rq.req_type == REQ_ALLOC) begin
      if (rq.size_bytes == 0) begin
        r.status = ST_ZERO;
      end else begin
        need = blocks_for(rq.size_bytes);
        run = 0; start = 0; found = 0;
        for (int i = 0; i < NBLK && !found; i++) begin
          if (blk_state[i] == BLK_FREE) begin
            if (run == 0) start = i;
            run++;
            if (run >= need) found = 1;
          end else begin
            run = 0;
          end
        end
        if (!found) begin
          r.status = ST_NOSPACE;
        end else begin
          for (longint i = 0; i < need; i++) begin
            blk_state[start + i] = BLK_ALLOC;
            blk_owner_size[start + i] = rq.size_bytes;
          end
          t = used_total + need * BBYTES;
          used_total = (t > USED_MAX) ? USED_MAX : t;
          r.status = ST_OK;
          r.result_address = 20'(start * BBYTES + HDR);
          r.first_block = 8'(start);
          r.block_count = 9'(need);
        end
      end
    end else if (rq.req_type == REQ_FREE) begin
      idx = (longint'(rq.address) - HDR) / BBYTES;
      if (rq.address == 0 || rq.address < HDR || rq.address < win_lo ||
          rq.address > win_hi || idx >= NBLK || blk_state[idx] != BLK_ALLOC) begin
        r.status = ST_BADPTR;
      end else begin
        n = blocks_for(blk_owner_size[idx]);
        if (n > NBLK - idx) n = NBLK - idx;
        for (longint i = 0; i < n; i++) begin
          if (blk_state[idx + i] == BLK_ALLOC) begin
            blk_state[idx + i] = BLK_FREE;
            blk_owner_size[idx + i] = '0;
          end
        end
        t = n * BBYTES;
        used_total = (t >= used_total) ? '0 : 21'(used_total - t);
        r.status = ST_OK;
        r.first_block = 8'(idx);
        r.block_count = 9'(n);
      end
    end else if (rq.req_type == REQ_STATS) begin
      nfree = 0; nalloc = 0; runs = 0; in_run = 0;
      for (int i = 0; i < NBLK; i++) begin
        if (blk_state[i] == BLK_FREE) begin
          nfree++;
          if (!in_run) runs++;
          in_run = 1;
        end else begin
          if (blk_state[i] == BLK_ALLOC) nalloc++;
          in_run = 0;
        end
      end
      r.status = ST_OK;
      r.free_block_total = 9'(nfree);
      r.allocated_block_total = 9'(nalloc);
      r.fragmentation_pct = nfree ? 7'((runs * PCT_SCALE) / nfree) : '0;
    end
    r.heap_used_bytes = used_total;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    resp_seen = 0;
    alloc_ok_seen = 0;
    free_ok_seen = 0;
  end

  assign pending = expected_rsp.size();

  always @(posedge clk) begin
    rsp_t r, w;
    if (rst) begin
      for (int i = 0; i < NBLK; i++) begin
        blk_state[i] = (i < RSV) ? BLK_SYS : BLK_FREE;
        blk_owner_size[i] = '0;
      end
      used_total = '0;
      win_lo = HEAP_FIRST_RESET;
      win_hi = HEAP_LAST_RESET;
      expected_rsp.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HEAP_FIRST) win_lo = cfg_data;
        else win_hi = cfg_data;
      end
      if (in_valid && in_ready) begin
        predict(in_data, r);
        expected_rsp.push_back(r);
      end
      if (out_valid && out_ready) begin
        resp_seen++;
        if (expected_rsp.size() == 0) begin
          report("unexpected transaction", 1, 0);
        end else begin
          w = expected_rsp.pop_front();
          if (w.status == ST_OK && w.block_count != 0) begin
            if (w.result_address != 0) alloc_ok_seen++;
            else free_ok_seen++;
          end
          if (out_data.status != w.status)
            report("status", out_data.status, w.status);
          if (out_data.result_address != w.result_address)
            report("result_address", out_data.result_address, w.result_address);
          if (out_data.first_block != w.first_block)
            report("first_block", out_data.first_block, w.first_block);
          if (out_data.block_count != w.block_count)
            report("block_count", out_data.block_count, w.block_count);
          if (out_data.free_block_total != w.free_block_total)
            report("free_block_total", out_data.free_block_total, w.free_block_total);
          if (out_data.allocated_block_total != w.allocated_block_total)
            report("allocated_block_total", out_data.allocated_block_total,
                   w.allocated_block_total);
          if (out_data.fragmentation_pct != w.fragmentation_pct)
            report("fragmentation_pct", out_data.fragmentation_pct, w.fragmentation_pct);
          if (out_data.heap_used_bytes != w.heap_used_bytes)
            report("heap_used_bytes", out_data.heap_used_bytes, w.heap_used_bytes);
        end
      end
    end
  end
endmodule

FILE: verif/tb_first_fit_block_allocator.sv
// testbench top for the first-fit block allocator: drives requests and
// heap window writes, stalls the response side, gives the verdict
// depends on ffba_pkg, first_fit_block_allocator and ffba_checker
module tb_first_fit_block_allocator;
  import ffba_pkg::*;

  logic           clk = 0;
  logic           rst = 1;
  logic           in_valid = 0;
  logic           in_ready;
  req_t           in_data = '0;
  logic           out_valid;
  logic           out_ready = 0;
  rsp_t           out_data;
  logic           cfg_we = 0;
  logic [0:0]     cfg_index = CFG_HEAP_FIRST;
  logic [19:0]    cfg_data = '0;
  int             fail_count, pending, resp_seen, alloc_ok_seen, free_ok_seen;
  bit             hold_off = 0;

  always #4 clk = ~clk;

  first_fit_block_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ffba_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .resp_seen(resp_seen),
    .alloc_ok_seen(alloc_ok_seen), .free_ok_seen(free_ok_seen)
  );

  // response side: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (gap == 0) begin
          out_ready <= 1;
        end else begin
          out_ready <= 0;
          repeat (gap) @(posedge clk);
          out_ready <= 1;
        end
      end
    end
  end

  task automatic send(input logic [1:0] kind, input logic [20:0] sz,
                      input logic [19:0] ptr);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{req_type: kind, size_bytes: sz, address: ptr};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_window(input logic [19:0] lo, input logic [19:0] hi);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= CFG_HEAP_FIRST; cfg_data <= lo;
    @(posedge clk);
    cfg_index <= CFG_HEAP_LAST; cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [19:0] some_ptr();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 20'(($urandom_range(0, 255) << 12) + 8);
    if (k < 8) return 20'(($urandom_range(0, 255) << 12) + $urandom_range(0, 4095));
    return 20'($urandom);
  endfunction

  task automatic random_phase(input int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45)
        send(REQ_ALLOC, ($urandom_range(0, 3) == 0) ? 21'($urandom) :
             21'($urandom_range(0, 20000)), 20'($urandom));
      else if (k < 85)
        send(REQ_FREE, 21'($urandom), some_ptr());
      else if (k < 97)
        send(REQ_STATS, 21'($urandom), 20'($urandom));
      else
        send(2'd3, 21'($urandom), 20'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    // directed
    send(REQ_STATS, '0, '0);
    send(REQ_ALLOC, 21'd0, '0);
    send(REQ_ALLOC, 21'd1, '0);
    send(REQ_ALLOC, 21'd4088, '0);
    send(REQ_ALLOC, 21'd4089, '0);
    send(REQ_ALLOC, 21'h100000, '0);
    send(REQ_ALLOC, 21'h1FFFFF, '0);
    send(REQ_STATS, '0, '0);
    send(REQ_FREE, '0, 20'd0);
    send(REQ_FREE, '0, 20'd4);
    send(REQ_FREE, '0, 20'd4096);
    send(REQ_FREE, '0, 20'hFFFFF);
    send(REQ_FREE, '0, 20'h20008);
    send(REQ_FREE, '0, 20'h21008);
    send(REQ_FREE, '0, 20'h23008);
    send(2'd3, 21'h1FFFFF, 20'hFFFFF);
    send(REQ_ALLOC, 21'd200000, '0);
    send(REQ_STATS, '0, '0);
    send(REQ_FREE, '0, 20'h26000);
    drain();
    write_window(20'd0, 20'hFFFFF);
    send(REQ_ALLOC, 21'd900000, '0);
    send(REQ_ALLOC, 21'd200000, '0);
    send(REQ_FREE, '0, 20'h20008);
    send(REQ_FREE, '0, 20'hF9000);
    send(REQ_STATS, '0, '0);
    // long receiver hold-off while requests keep coming
    hold_off = 1;
    random_phase(300);
    drain();
    write_window(20'h40000, 20'h80000);
    random_phase(200);
    drain();
    write_window(20'hFFFFF, 20'd0);
    random_phase(30);
    drain();
    write_window(20'd8, 20'hFFFFF);
    random_phase(170);
    drain();
    $display("covered %0d responses, %0d good allocations, %0d good frees",
             resp_seen, alloc_ok_seen, free_ok_seen);
    if (fail_count == 0)
      $display("PASS first_fit_block_allocator");
    else
      $display("FAIL first_fit_block_allocator");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL first_fit_block_allocator");
    $finish;
  end
endmodule
